[design/skvt_pkg.sv]
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and constants for the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

   localparam int KEY_W     = 32;
   localparam int VAL_W     = 32;
   localparam int CFG_W     = 9;
   localparam int TOTAL_W   = 9;
   localparam int STATUS_W  = 3;
   localparam int FUNC_W    = 2;

   localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 9'd257;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_FIND   = 2'd1,
      FUNC_DELETE = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 3'd0,
      STAT_INVALID = 3'd1,
      STAT_DUP     = 3'd2,
      STAT_FULL    = 3'd3,
      STAT_MISSING = 3'd4,
      STAT_EMPTY   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SEARCH_WAIT,
      S_PROBE,
      S_SHIFT,
      S_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic       load;
      logic       search_rd;
      logic       search_upd;
      logic       probe_rd;
      logic       status_load;
      status_type status;
      logic       found_take;
      logic       ins_start;
      logic       del_start;
      logic       shift_step;
      logic       ins_write;
      logic       count_inc;
      logic       count_dec;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      func_type func;
      logic     search_more;
      logic     hit;
      logic     key_invalid;
      logic     add_room;
      logic     empty;
      logic     shift_more;
      logic     pend;
   } dp_stat_type;

endpackage

[design/skvt_req_if.sv]
// ----------------------------------------------------------------------------
// skvt_req_if
// Request channel: one operation per beat.
// ----------------------------------------------------------------------------
interface skvt_req_if;
   logic                            valid;
   logic                            ready;
   logic [skvt_pkg::FUNC_W-1:0]     func;
   logic [skvt_pkg::KEY_W-1:0]      key;
   logic [skvt_pkg::VAL_W-1:0]      value;

   modport source (output valid, func, key, value, input ready);
   modport sink   (input valid, func, key, value, output ready);
endinterface

[design/skvt_rsp_if.sv]
// ----------------------------------------------------------------------------
// skvt_rsp_if
// Response channel: status, found value and entry count per beat.
// ----------------------------------------------------------------------------
interface skvt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [skvt_pkg::STATUS_W-1:0]   status;
   logic [skvt_pkg::VAL_W-1:0]      found_value;
   logic [skvt_pkg::TOTAL_W-1:0]    entry_total;

   modport source (output valid, status, found_value, entry_total, input ready);
   modport sink   (input valid, status, found_value, entry_total, output ready);
endinterface

[design/skvt_ram.sv]
// ----------------------------------------------------------------------------
// skvt_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module skvt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/skvt_datapath.sv]
// ----------------------------------------------------------------------------
// skvt_datapath
// Pair store, binary search bounds, shift pointer and response registers.
// ----------------------------------------------------------------------------
module skvt_datapath #(
   parameter int DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  skvt_pkg::dp_cmd_type             cmd,
   output skvt_pkg::dp_stat_type            stat,
   input  logic [skvt_pkg::FUNC_W-1:0]      req_func,
   input  logic [skvt_pkg::KEY_W-1:0]       req_key,
   input  logic [skvt_pkg::VAL_W-1:0]       req_value,
   input  logic                             csr_wr_en,
   input  logic [skvt_pkg::CFG_W-1:0]       csr_wr_data,
   output logic [skvt_pkg::STATUS_W-1:0]    rsp_status,
   output logic [skvt_pkg::VAL_W-1:0]       rsp_found_value,
   output logic [skvt_pkg::TOTAL_W-1:0]     rsp_entry_total
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W + 1 > skvt_pkg::CFG_W) ? CNT_W + 1 : skvt_pkg::CFG_W;
   localparam int PAIR_W = skvt_pkg::KEY_W + skvt_pkg::VAL_W;

   skvt_pkg::func_type               func_ff;
   logic [skvt_pkg::KEY_W-1:0]       key_ff;
   logic [skvt_pkg::VAL_W-1:0]       value_ff;
   logic [CNT_W-1:0]                 lo_ff, hi_ff, count_ff, ptr_ff;
   logic [ADDR_W-1:0]                mid_ff, pend_addr_ff;
   logic                             pend_ff, dir_down_ff;
   logic [skvt_pkg::CFG_W-1:0]       max_ff;
   skvt_pkg::status_type             status_ff;
   logic [skvt_pkg::VAL_W-1:0]       found_ff;
   logic [skvt_pkg::STATUS_W-1:0]    rsp_status_ff;
   logic [skvt_pkg::VAL_W-1:0]       rsp_found_ff;
   logic [skvt_pkg::TOTAL_W-1:0]     rsp_total_ff;

   logic [CNT_W-1:0]                 span, mid_full, ptr_inc, ptr_dec;
   logic [ADDR_W-1:0]                mid;
   logic [CMP_W-1:0]                 count_ext;
   logic                             shift_more;
   logic                             ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]                ram_wr_addr, ram_rd_addr;
   logic [PAIR_W-1:0]                ram_wr_data, ram_rd_data;
   logic [skvt_pkg::KEY_W-1:0]       rd_key;
   logic [skvt_pkg::VAL_W-1:0]       rd_val;

   assign span      = hi_ff - lo_ff;
   assign mid_full  = lo_ff + (span >> 1);
   assign mid       = mid_full[ADDR_W-1:0];
   assign ptr_inc   = ptr_ff + CNT_W'(1);
   assign ptr_dec   = ptr_ff - CNT_W'(1);
   assign count_ext = CMP_W'(count_ff);
   assign rd_key    = ram_rd_data[PAIR_W-1:skvt_pkg::VAL_W];
   assign rd_val    = ram_rd_data[skvt_pkg::VAL_W-1:0];
   assign shift_more = dir_down_ff ? (ptr_ff != count_ff) : (ptr_ff != lo_ff);

   always_comb begin
      stat.func        = func_ff;
      stat.search_more = lo_ff < hi_ff;
      stat.hit         = (lo_ff < count_ff) && (rd_key == key_ff);
      stat.key_invalid = &key_ff;
      stat.add_room    = (count_ext + CMP_W'(1) < CMP_W'(max_ff)) &&
                         (count_ff < CNT_W'(DEPTH));
      stat.empty       = count_ff == '0;
      stat.shift_more  = shift_more;
      stat.pend        = pend_ff;
   end

   // read port: search midpoint, probe at lower bound, or shift source
   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = mid;
      if (cmd.search_rd) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = mid;
      end else if (cmd.probe_rd) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = lo_ff[ADDR_W-1:0];
      end else if (cmd.shift_step && shift_more) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = dir_down_ff ? ptr_ff[ADDR_W-1:0] : ptr_dec[ADDR_W-1:0];
      end
   end

   always_comb begin
      ram_wr_en   = cmd.ins_write || pend_ff;
      ram_wr_addr = pend_addr_ff;
      ram_wr_data = ram_rd_data;
      if (cmd.ins_write) begin
         ram_wr_addr = lo_ff[ADDR_W-1:0];
         ram_wr_data = {key_ff, value_ff};
      end
   end

   skvt_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (DEPTH)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         max_ff   <= skvt_pkg::MAX_ENTRIES_RESET;
         pend_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
         if (cmd.count_inc) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.count_dec) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         pend_ff <= cmd.shift_step && shift_more;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= skvt_pkg::func_type'(req_func);
         key_ff   <= req_key;
         value_ff <= req_value;
         lo_ff    <= '0;
         hi_ff    <= count_ff;
      end else if (cmd.search_upd) begin
         if (rd_key < key_ff) begin
            lo_ff <= CNT_W'(mid_ff) + CNT_W'(1);
         end else begin
            hi_ff <= CNT_W'(mid_ff);
         end
      end
      if (cmd.search_rd) begin
         mid_ff <= mid;
      end
      if (cmd.ins_start) begin
         ptr_ff      <= count_ff;
         dir_down_ff <= 1'b0;
      end else if (cmd.del_start) begin
         ptr_ff      <= lo_ff + CNT_W'(1);
         dir_down_ff <= 1'b1;
      end else if (cmd.shift_step && shift_more) begin
         ptr_ff       <= dir_down_ff ? ptr_inc : ptr_dec;
         pend_addr_ff <= dir_down_ff ? ptr_dec[ADDR_W-1:0] : ptr_ff[ADDR_W-1:0];
      end
      if (cmd.status_load) begin
         status_ff <= cmd.status;
         found_ff  <= cmd.found_take ? rd_val : '0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
         rsp_total_ff  <= count_ext[skvt_pkg::TOTAL_W-1:0];
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;
   assign rsp_entry_total = rsp_total_ff;

endmodule

[design/skvt_ctrl.sv]
// ----------------------------------------------------------------------------
// skvt_ctrl
// Operation sequencer: search, probe, shift, respond.
// ----------------------------------------------------------------------------
module skvt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  skvt_pkg::dp_stat_type   stat,
   output skvt_pkg::dp_cmd_type    cmd
);

   skvt_pkg::ctrl_state_type state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skvt_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.status = skvt_pkg::STAT_OK;
      req_ready = 1'b0;
      unique case (state_ff)
         skvt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = skvt_pkg::S_SEARCH;
            end
         end
         skvt_pkg::S_SEARCH: begin
            if (stat.search_more) begin
               cmd.search_rd = 1'b1;
               state_in      = skvt_pkg::S_SEARCH_WAIT;
            end else begin
               cmd.probe_rd = 1'b1;
               state_in     = skvt_pkg::S_PROBE;
            end
         end
         skvt_pkg::S_SEARCH_WAIT: begin
            cmd.search_upd = 1'b1;
            state_in       = skvt_pkg::S_SEARCH;
         end
         skvt_pkg::S_PROBE: begin
            cmd.status_load = 1'b1;
            state_in        = skvt_pkg::S_DONE;
            case (stat.func)
               skvt_pkg::FUNC_ADD: begin
                  if (stat.key_invalid) begin
                     cmd.status = skvt_pkg::STAT_INVALID;
                  end else if (stat.hit) begin
                     cmd.status = skvt_pkg::STAT_DUP;
                  end else if (!stat.add_room) begin
                     cmd.status = skvt_pkg::STAT_FULL;
                  end else begin
                     cmd.ins_start = 1'b1;
                     state_in      = skvt_pkg::S_SHIFT;
                  end
               end
               skvt_pkg::FUNC_FIND: begin
                  if (stat.hit) begin
                     cmd.found_take = 1'b1;
                  end else begin
                     cmd.status = skvt_pkg::STAT_MISSING;
                  end
               end
               skvt_pkg::FUNC_DELETE: begin
                  if (stat.empty) begin
                     cmd.status = skvt_pkg::STAT_EMPTY;
                  end else if (!stat.hit) begin
                     cmd.status = skvt_pkg::STAT_MISSING;
                  end else begin
                     cmd.del_start = 1'b1;
                     state_in      = skvt_pkg::S_SHIFT;
                  end
               end
               default: begin
                  cmd.status = skvt_pkg::STAT_OK;
               end
            endcase
         end
         skvt_pkg::S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (!stat.shift_more && !stat.pend) begin
               if (stat.func == skvt_pkg::FUNC_ADD) begin
                  cmd.ins_write = 1'b1;
                  cmd.count_inc = 1'b1;
               end else begin
                  cmd.count_dec = 1'b1;
               end
               state_in = skvt_pkg::S_DONE;
            end
         end
         skvt_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = skvt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = skvt_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[design/sorted_key_value_table.sv]
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Key/value table kept in ascending key order: add, find, delete by key.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         beat contents
//  req_chan  in   valid/ready       func, key, value
//  rsp_chan  out  valid/ready       status, found_value, entry_total
//  csr_*     in   csr_wr_en         csr_wr_data = max_entries
//
//  One operation at a time. Binary search: each halving reads the midpoint
//  (S_SEARCH) and then updates the bounds (S_SEARCH_WAIT); the lower bound
//  is then probed (S_PROBE). Add/delete then move one entry per cycle
//  through the pair RAM (S_SHIFT) before the response is loaded (S_DONE).
//  Reset empties the table and sets max_entries to 257; no RAM clear.
//  A waiting response does not block the next request.
// ----------------------------------------------------------------------------
module sorted_key_value_table #(
   parameter int DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   skvt_req_if.sink                       req_chan,
   skvt_rsp_if.source                     rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [skvt_pkg::CFG_W-1:0]     csr_wr_data
);

   skvt_pkg::dp_cmd_type  dp_cmd;
   skvt_pkg::dp_stat_type dp_stat;

   skvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   skvt_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .stat            (dp_stat),
      .req_func        (req_chan.func),
      .req_key         (req_chan.key),
      .req_value       (req_chan.value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_status      (rsp_chan.status),
      .rsp_found_value (rsp_chan.found_value),
      .rsp_entry_total (rsp_chan.entry_total)
   );

   a_ins_no_collide: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.ins_write |-> !dp_stat.pend)
      else $error("insert write collides with pending shift write");

   a_inc_has_room: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.count_inc |-> dp_stat.add_room && !dp_stat.key_invalid)
      else $error("entry count raised without room");

   a_dec_not_empty: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.count_dec |-> !dp_stat.empty)
      else $error("entry count lowered on empty table");

   a_load_then_search: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load |=> !req_chan.ready)
      else $error("request taken while an operation is in flight");

endmodule

[verif/tb_sorted_key_value_table.sv]
// ----------------------------------------------------------------------------
// tb_sorted_key_value_table
// Self-checking bench for the sorted key/value table. A scripted opening
// covers the empty table, the all-ones key, duplicates, extreme keys and
// values, and deletes at the head, middle and tail. Random add/find/delete
// traffic follows under several capacity limits. Those limits include 0, 1,
// 2, 256, 257 and 511, and one phase fills the table to its storage bound.
// Every response beat is compared field by field against a scripted expectation
// or an in-bench model of the sorted store.
// ----------------------------------------------------------------------------
module tb_sorted_key_value_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 256;

   typedef struct packed {
      skvt_pkg::status_type                status;
      logic [skvt_pkg::VAL_W-1:0]          found_value;
      logic [skvt_pkg::TOTAL_W-1:0]        entry_total;
   } table_reply_type;

   typedef struct packed {
      skvt_pkg::func_type                  func;
      logic [skvt_pkg::KEY_W-1:0]          key;
      logic [skvt_pkg::VAL_W-1:0]          value;
      bit                                  typed;
      skvt_pkg::status_type                status;
      logic [skvt_pkg::VAL_W-1:0]          found_value;
      logic [skvt_pkg::TOTAL_W-1:0]        entry_total;
   } script_row_type;

   localparam script_row_type SCRIPT [25] = '{
      '{skvt_pkg::FUNC_FIND,   32'h0000_0000, 32'h0000_0000,
        1'b1, skvt_pkg::STAT_MISSING, 32'h0, 9'd0},
      '{skvt_pkg::FUNC_DELETE, 32'h0000_0005, 32'h0000_0000,
        1'b1, skvt_pkg::STAT_EMPTY,   32'h0, 9'd0},
      '{skvt_pkg::FUNC_ADD,    32'hFFFF_FFFF, 32'h0000_0001,
        1'b1, skvt_pkg::STAT_INVALID, 32'h0, 9'd0},
      '{skvt_pkg::FUNC_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF,
        1'b1, skvt_pkg::STAT_OK,      32'h0, 9'd0},
      '{skvt_pkg::FUNC_ADD,    32'h0000_0000, 32'hFFFF_FFFF,
        1'b1, skvt_pkg::STAT_OK,      32'h0, 9'd1},
      '{skvt_pkg::FUNC_ADD,    32'hFFFF_FFFE, 32'h0000_0000,
        1'b1, skvt_pkg::STAT_OK,      32'h0, 9'd2},
      '{skvt_pkg::FUNC_ADD,    32'h0000_0000, 32'h0000_1234,
        1'b1, skvt_pkg::STAT_DUP,     32'h0, 9'd2},
      '{skvt_pkg::FUNC_ADD,    32'hFFFF_FFFF, 32'h0000_0000,
        1'b1, skvt_pkg::STAT_INVALID, 32'h0, 9'd2},
      '{skvt_pkg::FUNC_FIND,   32'h0000_0000, 32'h0000_0000,
        1'b1, skvt_pkg::STAT_OK,      32'hFFFF_FFFF, 9'd2},
      '{skvt_pkg::FUNC_FIND,   32'hFFFF_FFFE, 32'h0000_0000,
        1'b1, skvt_pkg::STAT_OK,      32'h0, 9'd2},
      '{skvt_pkg::FUNC_FIND,   32'hFFFF_FFFF, 32'h0000_0000,
        1'b1, skvt_pkg::STAT_MISSING, 32'h0, 9'd2},
      '{skvt_pkg::FUNC_ADD,    32'h8000_0000, 32'hA5A5_A5A5,
        1'b0, skvt_pkg::STAT_OK,      32'h0, 9'd0},
      '{skvt_pkg::FUNC_ADD,    32'h7FFF_FFFF, 32'h5A5A_5A5A,
        1'b0, skvt_pkg::STAT_OK,      32'h0, 9'd0},
      '{skvt_pkg::FUNC_ADD,    32'h0000_0001, 32'hC3C3_C3C3,
        1'b0, skvt_pkg::STAT_OK,      32'h0, 9'd0},
      '{skvt_pkg::FUNC_FIND,   32'h8000_0000, 32'h0000_0000,
        1'b0, skvt_pkg::STAT_OK,      32'h0, 9'd0},
      '{skvt_pkg::FUNC_FIND,   32'h7FFF_FFFF, 32'h0000_0000,
        1'b0, skvt_pkg::STAT_OK,      32'h0, 9'd0},
      '{skvt_pkg::FUNC_DELETE, 32'h1234_5678, 32'h0000_0000,
        1'b1, skvt_pkg::STAT_MISSING, 32'h0, 9'd5},
      '{skvt_pkg::FUNC_DELETE, 32'h0000_0000, 32'h0000_0000,
        1'b0, skvt_pkg::STAT_OK,      32'h0, 9'd0},
      '{skvt_pkg::FUNC_DELETE, 32'hFFFF_FFFE, 32'h0000_0000,
        1'b0, skvt_pkg::STAT_OK,      32'h0, 9'd0},
      '{skvt_pkg::FUNC_FIND,   32'h0000_0000, 32'h0000_0000,
        1'b0, skvt_pkg::STAT_OK,      32'h0, 9'd0},
      '{skvt_pkg::FUNC_NONE,   32'h0000_0000, 32'h0000_0000,
        1'b0, skvt_pkg::STAT_OK,      32'h0, 9'd0},
      '{skvt_pkg::FUNC_DELETE, 32'h7FFF_FFFF, 32'h0000_0000,
        1'b0, skvt_pkg::STAT_OK,      32'h0, 9'd0},
      '{skvt_pkg::FUNC_FIND,   32'h0000_0001, 32'h0000_0000,
        1'b0, skvt_pkg::STAT_OK,      32'h0, 9'd0},
      '{skvt_pkg::FUNC_DELETE, 32'h0000_0001, 32'h0000_0000,
        1'b0, skvt_pkg::STAT_OK,      32'h0, 9'd0},
      '{skvt_pkg::FUNC_DELETE, 32'h8000_0000, 32'h0000_0000,
        1'b0, skvt_pkg::STAT_OK,      32'h0, 9'd0}
   };

   logic                          clock;
   logic                          reset;
   logic                          csr_wr_en;
   logic [skvt_pkg::CFG_W-1:0]    csr_wr_data;

   skvt_req_if req_bus ();
   skvt_rsp_if rsp_bus ();

   sorted_key_value_table #(.DEPTH(TABLE_DEPTH)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // model of the sorted store
   logic [skvt_pkg::KEY_W-1:0]    tbl_keys [TABLE_DEPTH];
   logic [skvt_pkg::VAL_W-1:0]    tbl_vals [TABLE_DEPTH];
   int                            tbl_count;
   int                            tbl_limit;

   table_reply_type               pending_replies [$];
   int                            error_count;
   int                            beats_sent;
   int                            limits_used;
   int                            peak_count;
   int                            status_seen [6];
   int                            send_idle_pct;
   int                            recv_idle_pct;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #30ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic table_reply_type apply_table_op(
         input skvt_pkg::func_type f,
         input logic [skvt_pkg::KEY_W-1:0] k,
         input logic [skvt_pkg::VAL_W-1:0] v);
      table_reply_type r;
      int lo;
      int hi;
      int mid;
      bit hit;
      lo = 0;
      hi = tbl_count;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (tbl_keys[mid] < k) lo = mid + 1;
         else hi = mid;
      end
      hit = (lo < tbl_count) && (tbl_keys[lo] == k);
      r.status = skvt_pkg::STAT_OK;
      r.found_value = '0;
      case (f)
         skvt_pkg::FUNC_ADD: begin
            if (k == '1) r.status = skvt_pkg::STAT_INVALID;
            else if (hit) r.status = skvt_pkg::STAT_DUP;
            else if (!(tbl_count + 1 < tbl_limit) || tbl_count >= TABLE_DEPTH)
               r.status = skvt_pkg::STAT_FULL;
            else begin
               for (int i = tbl_count; i > lo; i--) begin
                  tbl_keys[i] = tbl_keys[i-1];
                  tbl_vals[i] = tbl_vals[i-1];
               end
               tbl_keys[lo] = k;
               tbl_vals[lo] = v;
               tbl_count++;
            end
         end
         skvt_pkg::FUNC_FIND: begin
            if (hit) r.found_value = tbl_vals[lo];
            else r.status = skvt_pkg::STAT_MISSING;
         end
         skvt_pkg::FUNC_DELETE: begin
            if (tbl_count == 0) r.status = skvt_pkg::STAT_EMPTY;
            else if (!hit) r.status = skvt_pkg::STAT_MISSING;
            else begin
               for (int i = lo; i < tbl_count - 1; i++) begin
                  tbl_keys[i] = tbl_keys[i+1];
                  tbl_vals[i] = tbl_vals[i+1];
               end
               tbl_count--;
            end
         end
         default: ;
      endcase
      if (tbl_count > peak_count) peak_count = tbl_count;
      r.entry_total = tbl_count[skvt_pkg::TOTAL_W-1:0];
      return r;
   endfunction

   function automatic logic [skvt_pkg::KEY_W-1:0] pick_key(input int hit_pct,
                                                           input int key_span);
      int r;
      r = $urandom_range(0, 99);
      if (tbl_count > 0 && r < hit_pct)
         return tbl_keys[$urandom_range(0, tbl_count - 1)];
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r == 2) return 32'hFFFF_FFFE;
      if (key_span != 0 && r < 15) return $urandom_range(0, key_span);
      return $urandom;
   endfunction

   task automatic issue_op(input skvt_pkg::func_type f,
                           input logic [skvt_pkg::KEY_W-1:0] k,
                           input logic [skvt_pkg::VAL_W-1:0] v, input bit typed,
                           input table_reply_type fixed);
      table_reply_type r;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func  <= f;
      req_bus.key   <= k;
      req_bus.value <= v;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      r = apply_table_op(f, k, v);
      pending_replies.push_back(typed ? fixed : r);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_replies.size() != 0);
   endtask

   task automatic set_limit(input logic [skvt_pkg::CFG_W-1:0] lim);
      hold_until_drained();
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lim;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      tbl_limit = int'(lim);
      limits_used++;
   endtask

   task automatic run_mix(input int n, input int add_w, input int find_w,
                          input int del_w, input int hit_pct, input int key_span);
      int r;
      skvt_pkg::func_type f;
      logic [skvt_pkg::KEY_W-1:0] k;
      logic [skvt_pkg::VAL_W-1:0] v;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < add_w) f = skvt_pkg::FUNC_ADD;
         else if (r < add_w + find_w) f = skvt_pkg::FUNC_FIND;
         else if (r < add_w + find_w + del_w) f = skvt_pkg::FUNC_DELETE;
         else f = skvt_pkg::FUNC_NONE;
         k = pick_key(f == skvt_pkg::FUNC_ADD ? hit_pct / 4 : hit_pct, key_span);
         r = $urandom_range(0, 9);
         v = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
         issue_op(f, k, v, 1'b0, '0);
         if ($urandom_range(0, 199) == 0) hold_until_drained();
      end
   endtask

   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

   always @(posedge clock) begin
      table_reply_type exp;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (rsp_bus.status < 6) status_seen[rsp_bus.status]++;
         if (pending_replies.size() == 0) begin
            $error("unexpected response beat: status %0d", rsp_bus.status);
            error_count++;
         end else begin
            exp = pending_replies.pop_front();
            if (rsp_bus.status !== exp.status) begin
               $error("status: expected %0d, got %0d", exp.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.found_value !== exp.found_value) begin
               $error("found_value: expected %h, got %h", exp.found_value,
                      rsp_bus.found_value);
               error_count++;
            end
            if (rsp_bus.entry_total !== exp.entry_total) begin
               $error("entry_total: expected %0d, got %0d", exp.entry_total,
                      rsp_bus.entry_total);
               error_count++;
            end
         end
      end
   end

   initial begin
      table_reply_type fixed;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.func   = skvt_pkg::FUNC_ADD;
      req_bus.key    = '0;
      req_bus.value  = '0;
      rsp_bus.ready  = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      tbl_count      = 0;
      tbl_limit      = int'(skvt_pkg::MAX_ENTRIES_RESET);
      error_count    = 0;
      beats_sent     = 0;
      limits_used    = 1;
      peak_count     = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      send_idle_pct  = 11;
      recv_idle_pct  = 76;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (SCRIPT[i]) begin
         fixed = '{SCRIPT[i].status, SCRIPT[i].found_value, SCRIPT[i].entry_total};
         issue_op(SCRIPT[i].func, SCRIPT[i].key, SCRIPT[i].value, SCRIPT[i].typed, fixed);
      end

      run_mix(330, 45, 28, 22, 60, 63);
      set_limit(9'd0);
      run_mix(30, 60, 20, 10, 60, 63);
      set_limit(9'd1);
      run_mix(30, 60, 20, 10, 60, 63);
      // drain toward empty so a single add fits
      set_limit(9'd2);
      run_mix(120, 20, 15, 60, 80, 63);

      hold_until_drained();
      send_idle_pct = 76;
      recv_idle_pct = 11;
      // storage bound: fill all entries
      set_limit(9'd511);
      run_mix(380, 90, 6, 2, 50, 0);
      set_limit(9'd257);
      run_mix(40, 40, 20, 35, 70, 0);
      set_limit(9'd256);
      run_mix(40, 45, 20, 30, 70, 0);

      hold_until_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_limit(9'($urandom_range(3, 255)));
      run_mix(200, 15, 20, 60, 80, 0);
      run_mix(150, 40, 30, 25, 60, 1023);

      hold_until_drained();
      repeat (300) @(posedge clock);
      $display("Summary: %0d beats over %0d capacity settings, peak of %0d entries held.",
               beats_sent, limits_used, peak_count);
      $display("Status mix: ok %0d, invalid %0d, duplicate %0d, full %0d, %s %0d, empty %0d.",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               "not found", status_seen[4], status_seen[5]);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

[filelist.f]
design/skvt_pkg.sv
design/skvt_req_if.sv
design/skvt_rsp_if.sv
design/skvt_ram.sv
design/skvt_datapath.sv
design/skvt_ctrl.sv
design/sorted_key_value_table.sv
verif/tb_sorted_key_value_table.sv
